>>> rtl/keypad_mmss_countdown_timer_macros.svh
// Assertion macros for the timer RTL.
`ifndef KEYPAD_MMSS_COUNTDOWN_TIMER_MACROS_SVH
`define KEYPAD_MMSS_COUNTDOWN_TIMER_MACROS_SVH
`ifndef SYNTH
// The condition holds at every clock edge out of reset.
`define KMT_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("timer assertion failed");
// The consequent holds in the cycle of the antecedent.
`define KMT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("timer assertion failed");
// The consequent holds in the cycle after the antecedent.
`define KMT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("timer assertion failed");
`else
`define KMT_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define KMT_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define KMT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/kmt_pkg.sv
package kmt_pkg;

    localparam int ENTRY_DIGITS = 4;
    localparam int ENTRY_IDX_W  = $clog2(ENTRY_DIGITS);
    localparam int PRESET_COUNT = 6;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 13;

    typedef logic [ENTRY_IDX_W-1:0] entry_count_t;
    typedef logic [CFG_IDX_W-1:0]   cfg_index_t;
    typedef logic [CFG_DATA_W-1:0]  cfg_data_t;
    typedef logic [1:0]             action_t;

    localparam action_t ACT_KEY    = 2'd0;
    localparam action_t ACT_PRESET = 2'd1;
    localparam action_t ACT_TICK   = 2'd2;
    localparam action_t ACT_NONE   = 2'd3;

    localparam logic [3:0] KEY_DIGIT_MAX = 4'd9;

    localparam entry_count_t ENTRY_LAST = ENTRY_IDX_W'(ENTRY_DIGITS - 1);

    localparam cfg_data_t PRESET_MAX = 13'd6039;

    // Division by 60 as a multiply by ceil(2^19 / 60) and a shift; exact for
    // every value up to PRESET_MAX.
    localparam logic [13:0] DIV60_RECIP = 14'd8739;
    localparam int          DIV60_SHIFT = 19;

    localparam logic [6:0] SS_WRAP = 7'd60;
    localparam logic [5:0] SS_TOP  = 6'd59;
    localparam logic [6:0] MM_MAX  = 7'd100;

    localparam logic [2:0] BEEP_NONE = 3'd0;
    localparam logic [2:0] BEEP_ONE  = 3'd1;
    localparam logic [2:0] BEEP_DONE = 3'd4;

    // Reset presets of 30, 60, 90, 120, 150 and 180 seconds as mm:ss.
    localparam logic [6:0] PRESET_MM_RST [PRESET_COUNT] =
        '{7'd0, 7'd1, 7'd1, 7'd2, 7'd2, 7'd3};
    localparam logic [5:0] PRESET_SS_RST [PRESET_COUNT] =
        '{6'd30, 6'd0, 6'd30, 6'd0, 6'd30, 6'd0};

    typedef struct packed {
        action_t    action;
        logic [3:0] key_code;
        logic [2:0] preset_index;
    } kmt_item_t;

    typedef struct packed {
        logic       valid;
        logic [6:0] minutes;
        logic [5:0] seconds;
    } kmt_preset_t;

    typedef struct packed {
        logic         running;
        logic [6:0]   minutes_left;
        logic [5:0]   seconds_left;
        entry_count_t digits_entered;
        logic [2:0]   beep_count;
        logic         done_pulse;
        logic         motor_on;
    } kmt_result_t;

endpackage

>>> rtl/kmt_in_if.sv
interface kmt_in_if;
    import kmt_pkg::*;

    logic       valid;
    logic       ready;
    action_t    action;
    logic [3:0] key_code;
    logic [2:0] preset_index;

    modport source (output valid, action, key_code, preset_index, input ready);
    modport sink   (input valid, action, key_code, preset_index, output ready);
endinterface

>>> rtl/kmt_out_if.sv
interface kmt_out_if;
    import kmt_pkg::*;

    logic         valid;
    logic         ready;
    logic         running;
    logic [6:0]   minutes_left;
    logic [5:0]   seconds_left;
    entry_count_t digits_entered;
    logic [2:0]   beep_count;
    logic         done_pulse;
    logic         motor_on;

    modport source (
        output valid, running, minutes_left, seconds_left, digits_entered,
               beep_count, done_pulse, motor_on,
        input  ready
    );
    modport sink (
        input  valid, running, minutes_left, seconds_left, digits_entered,
               beep_count, done_pulse, motor_on,
        output ready
    );
endinterface

>>> rtl/kmt_preset_bank.sv
module kmt_preset_bank (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  kmt_pkg::cfg_index_t  cfg_index,
    input  kmt_pkg::cfg_data_t   cfg_wdata,
    input  logic [2:0]           rd_index,
    output kmt_pkg::kmt_preset_t rd_preset
);
    import kmt_pkg::*;

    // Presets are kept as mm:ss, converted once when written.
    logic [6:0]  mm_reg [PRESET_COUNT];
    logic [5:0]  ss_reg [PRESET_COUNT];

    cfg_data_t   sat;
    logic [26:0] prod;
    logic [6:0]  quo;
    cfg_data_t   quo_x60;
    cfg_data_t   rem;
    logic        wr_hit;
    logic        rd_hit;

    always_comb
    begin
        sat     = (cfg_wdata > PRESET_MAX) ? PRESET_MAX : cfg_wdata;
        prod    = 27'(sat) * 27'(DIV60_RECIP);
        quo     = prod[DIV60_SHIFT +: 7];
        quo_x60 = {quo, 6'b0} - {4'b0, quo, 2'b0};
        rem     = sat - quo_x60;
        wr_hit  = cfg_wr_en && (cfg_index < CFG_IDX_W'(PRESET_COUNT));
        rd_hit  = rd_index < 3'(PRESET_COUNT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PRESET_COUNT; i++)
            begin
                mm_reg[i] <= PRESET_MM_RST[i];
                ss_reg[i] <= PRESET_SS_RST[i];
            end
        end
        else if (wr_hit)
        begin
            mm_reg[cfg_index] <= quo;
            ss_reg[cfg_index] <= rem[5:0];
        end
    end

    assign rd_preset.valid   = rd_hit;
    assign rd_preset.minutes = rd_hit ? mm_reg[rd_index] : 7'd0;
    assign rd_preset.seconds = rd_hit ? ss_reg[rd_index] : 6'd0;

endmodule

>>> rtl/kmt_step.sv
`include "keypad_mmss_countdown_timer_macros.svh"

module kmt_step (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step_en,
    input  kmt_pkg::kmt_item_t   item,
    input  kmt_pkg::kmt_preset_t preset,
    output kmt_pkg::kmt_result_t result
);
    import kmt_pkg::*;

    logic [6:0]   minutes_reg, minutes_next;
    logic [5:0]   seconds_reg, seconds_next;
    logic         run_reg, run_next;
    entry_count_t count_reg, count_next;
    // Only the first three digits are stored; the last one comes straight in.
    logic [3:0]   digits_reg [ENTRY_DIGITS-1];

    logic         digit_ok;
    logic         digit_wr;
    logic [6:0]   key_mm;
    logic [6:0]   key_ss_raw;
    logic         key_carry;
    logic [6:0]   key_ss_adj;
    logic [2:0]   beep;
    logic         done;

    always_comb
    begin
        digit_ok   = (item.action == ACT_KEY) && !run_reg && (item.key_code <= KEY_DIGIT_MAX);
        key_mm     = {digits_reg[0], 3'b0} + {2'b0, digits_reg[0], 1'b0}
                   + {3'b0, digits_reg[1]};
        key_ss_raw = {digits_reg[2], 3'b0} + {2'b0, digits_reg[2], 1'b0}
                   + {3'b0, item.key_code};
        key_carry  = key_ss_raw >= SS_WRAP;
        key_ss_adj = key_carry ? (key_ss_raw - SS_WRAP) : key_ss_raw;

        minutes_next = minutes_reg;
        seconds_next = seconds_reg;
        run_next     = run_reg;
        count_next   = count_reg;
        digit_wr     = 1'b0;
        beep         = BEEP_NONE;
        done         = 1'b0;

        unique case (item.action)
            ACT_KEY:
            begin
                if (digit_ok)
                begin
                    beep = BEEP_ONE;
                    if (count_reg == ENTRY_LAST)
                    begin
                        minutes_next = key_mm + {6'b0, key_carry};
                        seconds_next = key_ss_adj[5:0];
                        run_next     = 1'b1;
                        count_next   = '0;
                    end
                    else
                    begin
                        digit_wr   = 1'b1;
                        count_next = count_reg + entry_count_t'(1);
                    end
                end
            end
            ACT_PRESET:
            begin
                if (preset.valid)
                begin
                    minutes_next = preset.minutes;
                    seconds_next = preset.seconds;
                    run_next     = 1'b1;
                    beep         = BEEP_ONE;
                end
            end
            ACT_TICK:
            begin
                if (run_reg)
                begin
                    if ((minutes_reg == 7'd0) && (seconds_reg == 6'd0))
                    begin
                        run_next   = 1'b0;
                        done       = 1'b1;
                        beep       = BEEP_DONE;
                        count_next = '0;
                    end
                    else if (seconds_reg == 6'd0)
                    begin
                        seconds_next = SS_TOP;
                        minutes_next = minutes_reg - 7'd1;
                    end
                    else
                    begin
                        seconds_next = seconds_reg - 6'd1;
                    end
                end
            end
            default:
            begin
                // The unused action code leaves everything as it is.
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            minutes_reg <= '0;
            seconds_reg <= '0;
            run_reg     <= 1'b0;
            count_reg   <= '0;
        end
        else if (step_en)
        begin
            minutes_reg <= minutes_next;
            seconds_reg <= seconds_next;
            run_reg     <= run_next;
            count_reg   <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en && digit_wr)
        begin
            digits_reg[count_reg] <= item.key_code;
        end
    end

    assign result.running        = run_next;
    assign result.minutes_left   = minutes_next;
    assign result.seconds_left   = seconds_next;
    assign result.digits_entered = count_next;
    assign result.beep_count     = beep;
    assign result.done_pulse     = done;
    assign result.motor_on       = run_next;

    `KMT_ASSERT_ALWAYS(a_seconds_range, clk, rst_n, seconds_reg <= SS_TOP)
    `KMT_ASSERT_ALWAYS(a_minutes_range, clk, rst_n, minutes_reg <= MM_MAX)
    `KMT_ASSERT_IMPL(a_done_stops, clk, rst_n, done, !run_next && (beep == BEEP_DONE))
    `KMT_ASSERT_NEXT(a_entry_idle_run, clk, rst_n, step_en && digit_wr, !run_reg && (count_reg != '0))

endmodule

>>> rtl/keypad_mmss_countdown_timer.sv
// Keypad mm:ss countdown timer.
// The item channel carries one event per transfer: a keypad key, a preset
// button or a one-second tick. The result channel returns exactly one
// transfer per event with the run flag, the current mm:ss, the number of
// digits held in the entry, the beep count and the done pulse.
// The user must write presets through the configuration port only while no
// event is in flight; the block itself does not enforce this. Each write is
// saturated to 100:39 and stored as mm:ss. An accepted event lands in an
// input register, is evaluated against the timer state combinationally and
// leaves through the result register once that register is empty or is
// being emptied. While the receiver is ready, the two registers accept
// one event every cycle; their carry and borrow logic is combinational.
// When the receiver stalls, the result register holds its transfer and one
// more event waits in the input register; the item channel then drops ready.
// Reset clears the timer to 00:00, idle, with no digits entered, restores
// the default presets and empties both pipeline registers.
module keypad_mmss_countdown_timer (
    input  logic                clk,
    input  logic                rst_n,
    kmt_in_if.sink              item,
    kmt_out_if.source           result,
    input  logic                cfg_wr_en,
    input  kmt_pkg::cfg_index_t cfg_index,
    input  kmt_pkg::cfg_data_t  cfg_wdata
);
    import kmt_pkg::*;

    // Input register stage.
    logic        item_valid_reg;
    kmt_item_t   item_reg;

    // Result register stage.
    logic        out_valid_reg;
    kmt_result_t out_reg;

    kmt_preset_t preset;
    kmt_result_t step_result;
    logic        advance;
    logic        in_xfer;

    // The held event moves on whenever the result register is empty or is
    // being emptied in this cycle.
    assign advance    = item_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !item_valid_reg || advance;
    assign in_xfer    = item.valid && item.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            item_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            item_reg.action       <= item.action;
            item_reg.key_code     <= item.key_code;
            item_reg.preset_index <= item.preset_index;
        end
    end

    kmt_preset_bank u_preset_bank (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .rd_index  (item_reg.preset_index),
        .rd_preset (preset)
    );

    // Timer state advances only when the event's result is captured below.
    kmt_step u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .item    (item_reg),
        .preset  (preset),
        .result  (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= step_result;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.running        = out_reg.running;
    assign result.minutes_left   = out_reg.minutes_left;
    assign result.seconds_left   = out_reg.seconds_left;
    assign result.digits_entered = out_reg.digits_entered;
    assign result.beep_count     = out_reg.beep_count;
    assign result.done_pulse     = out_reg.done_pulse;
    assign result.motor_on       = out_reg.motor_on;

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import kmt_pkg::*;

    // Keys outside the digit range, named for readability.
    localparam logic [3:0] KEY_STAR = 4'd10;
    localparam logic [3:0] KEY_HASH = 4'd11;

    // Preset register i sits at configuration index REG_PRESET_ZERO + i.
    localparam cfg_index_t REG_PRESET_ZERO = '0;

    // Preset values that the block restores on reset, in total seconds.
    localparam cfg_data_t PRESET_DEFAULTS [PRESET_COUNT] =
        '{13'd30, 13'd60, 13'd90, 13'd120, 13'd150, 13'd180};

    // Phase 1 of the random part runs on the edges of the preset range.
    localparam cfg_data_t PRESET_EDGES [PRESET_COUNT] =
        '{13'd6039, 13'd0, 13'd8191, 13'd1, 13'd6038, 13'd59};

    // Above this many seconds left the random part reloads a short preset
    // now and then, so that countdowns stay short and end often.
    localparam int LONG_COUNTDOWN = 150;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_EVENTS   = 275;
    localparam int STALL_CYCLES   = 400;

    // Timer state as the predictor keeps it: run flag, mm:ss, and the digit
    // entry store with its fill count.
    typedef struct packed {
        logic            run;
        logic [6:0]      mm;
        logic [5:0]      ss;
        logic [2:0]      cnt;
        logic [3:0][3:0] dig;
    } timer_state_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_wr_en;
    cfg_index_t cfg_index;
    cfg_data_t  cfg_wdata;

    kmt_in_if  item_if ();
    kmt_out_if result_if ();

    keypad_mmss_countdown_timer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_if),
        .result    (result_if),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Preset registers as the testbench believes them to be.
    cfg_data_t preset_secs [PRESET_COUNT];

    // Two copies of the timer state. The planning copy runs ahead as events
    // are queued, so that the random part can see what the timer will be
    // doing and build well-formed sequences. The model copy only advances
    // when the block accepts an event, and it produces the readouts that the
    // result channel must match.
    timer_state_t plan_state;
    timer_state_t model_state;

    kmt_item_t   pending_events [$];
    kmt_result_t predicted_readouts [$];

    // Handshake bookkeeping for the driver, the receiver and the monitor, partly shared between them.
    bit item_taken;
    bit quiet_tail;
    bit pressure_go;
    bit stall_on;
    bit send_calm;
    bit recv_calm;
    int send_gap;
    int recv_gap;

    int errors;
    int events_accepted;
    int readouts_checked;
    int countdowns_done;
    int settings_used;

    // Computes the readout for one event and moves the timer state along.
    // Keys count only while idle and only for digits; the fourth digit turns
    // the entry into mm:ss, folding seconds of 60 and up into one more
    // minute, and starts the countdown. A preset saturates at 100:39 and
    // starts or restarts the countdown without touching the entry. A tick at
    // 00:00 stops a running timer with four beeps and clears the entry.
    function automatic kmt_result_t timer_advance(inout timer_state_t st,
                                                  input kmt_item_t ev);
        kmt_result_t r;
        int mins;
        int secs;
        int total;
        r = '0;
        r.beep_count = BEEP_NONE;
        case (ev.action)
            ACT_KEY:
            begin
                if (!st.run && ev.key_code <= KEY_DIGIT_MAX && st.cnt < ENTRY_DIGITS)
                begin
                    st.dig[st.cnt[1:0]] = ev.key_code;
                    st.cnt = st.cnt + 3'd1;
                    r.beep_count = BEEP_ONE;
                    if (st.cnt == ENTRY_DIGITS)
                    begin
                        mins = int'(st.dig[0]) * 10 + int'(st.dig[1]);
                        secs = int'(st.dig[2]) * 10 + int'(st.dig[3]);
                        if (secs >= int'(SS_WRAP))
                        begin
                            mins = mins + 1;
                            secs = secs - int'(SS_WRAP);
                        end
                        st.mm  = mins[6:0];
                        st.ss  = secs[5:0];
                        st.run = 1'b1;
                        st.cnt = '0;
                        st.dig = '0;
                    end
                end
            end
            ACT_PRESET:
            begin
                if (ev.preset_index < PRESET_COUNT)
                begin
                    total = int'(preset_secs[ev.preset_index]);
                    if (total > int'(PRESET_MAX))
                        total = int'(PRESET_MAX);
                    mins = total / int'(SS_WRAP);
                    secs = total % int'(SS_WRAP);
                    st.mm  = mins[6:0];
                    st.ss  = secs[5:0];
                    st.run = 1'b1;
                    r.beep_count = BEEP_ONE;
                end
            end
            ACT_TICK:
            begin
                if (st.run)
                begin
                    if (st.mm == '0 && st.ss == '0)
                    begin
                        st.run = 1'b0;
                        st.cnt = '0;
                        st.dig = '0;
                        r.done_pulse = 1'b1;
                        r.beep_count = BEEP_DONE;
                    end
                    else if (st.ss == '0)
                    begin
                        st.ss = SS_TOP;
                        st.mm = st.mm - 7'd1;
                    end
                    else
                    begin
                        st.ss = st.ss - 6'd1;
                    end
                end
            end
            default:
            begin
                // The unused action code leaves everything as it is.
            end
        endcase
        r.running        = st.run;
        r.minutes_left   = st.mm;
        r.seconds_left   = st.ss;
        r.digits_entered = st.cnt[1:0];
        r.motor_on       = st.run;
        return r;
    endfunction

    // Queues one event for the driver and runs it through the planning copy.
    task automatic queue_event(input action_t act, input logic [3:0] key,
                               input logic [2:0] idx);
        kmt_item_t ev;
        ev.action       = act;
        ev.key_code     = key;
        ev.preset_index = idx;
        pending_events.push_back(ev);
        void'(timer_advance(plan_state, ev));
    endtask

    // Random part. Most events belong to well-formed sequences: a digit
    // entry or a preset to start, then ticks down to done. The rest is
    // noise: ignored keys, out-of-range presets, the unused action, fully
    // random bit patterns, reloads while running and entries cut short by a
    // preset.
    task automatic plan_random_events(input int count);
        int n;
        int pick;
        int left;
        int shortest;
        int i;
        logic [3:0] digit;
        for (n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
            begin
                case ($urandom_range(0, 4))
                    0: queue_event(ACT_NONE, 4'($urandom), 3'($urandom));
                    1: queue_event(ACT_KEY, 4'($urandom_range(10, 15)), 3'($urandom));
                    2: queue_event(ACT_PRESET, 4'($urandom), 3'($urandom_range(6, 7)));
                    3: queue_event(action_t'($urandom_range(0, 3)), 4'($urandom),
                                   3'($urandom));
                    default: queue_event(ACT_TICK, 4'($urandom), 3'($urandom));
                endcase
            end
            else if (plan_state.run)
            begin
                left = int'(plan_state.mm) * int'(SS_WRAP) + int'(plan_state.ss);
                if (left > LONG_COUNTDOWN && $urandom_range(0, 3) == 0)
                begin
                    shortest = 0;
                    for (i = 1; i < PRESET_COUNT; i++)
                        if (preset_secs[i] < preset_secs[shortest])
                            shortest = i;
                    queue_event(ACT_PRESET, 4'($urandom), 3'(shortest));
                end
                else if (pick < 14)
                    queue_event(ACT_PRESET, 4'($urandom), 3'($urandom_range(0, 5)));
                else if (pick < 17)
                    queue_event(ACT_KEY, 4'($urandom_range(0, 9)), 3'($urandom));
                else
                    queue_event(ACT_TICK, 4'($urandom), 3'($urandom));
            end
            else if (plan_state.cnt == '0 && $urandom_range(0, 1) == 0)
            begin
                queue_event(ACT_PRESET, 4'($urandom), 3'($urandom_range(0, 5)));
            end
            else if (plan_state.cnt != '0 && pick < 15)
            begin
                queue_event(ACT_PRESET, 4'($urandom), 3'($urandom_range(0, 5)));
            end
            else
            begin
                // Keep the minutes mostly at zero so that countdowns end soon.
                digit = 4'($urandom_range(0, 9));
                if (plan_state.cnt == 3'd0 && $urandom_range(0, 9) != 0)
                    digit = 4'd0;
                if (plan_state.cnt == 3'd1 && $urandom_range(0, 6) != 0)
                    digit = 4'd0;
                queue_event(ACT_KEY, digit, 3'($urandom));
            end
        end
    endtask

    task automatic write_preset(input int idx, input cfg_data_t value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_PRESET_ZERO + cfg_index_t'(idx);
        cfg_wdata <= value;
        preset_secs[idx] = value;
    endtask

    // Returns once every queued event has been transferred and every
    // readout has come back.
    task automatic wait_until_idle();
        do
        begin
            @(negedge clk);
            #1;
        end
        while (pending_events.size() != 0 || item_if.valid
               || predicted_readouts.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, want, got);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Item driver. A new event is offered at the falling edge after the
    // previous one was transferred; random gaps come in bursts, except
    // during calm stretches, the receiver hold-off and the final phase.
    always @(negedge clk)
    begin : drive_items
        kmt_item_t next_item;
        if (rst_n && (!item_if.valid || item_taken))
        begin
            item_taken = 1'b0;
            if ($urandom_range(0, 63) == 0)
                send_calm = !send_calm;
            if (!send_calm && !quiet_tail && !stall_on && send_gap == 0
                && $urandom_range(0, 7) == 0)
                send_gap = $urandom_range(1, 18);
            if (send_gap > 0)
            begin
                send_gap--;
                item_if.valid <= 1'b0;
            end
            else if (pending_events.size() != 0)
            begin
                next_item = pending_events.pop_front();
                item_if.valid        <= 1'b1;
                item_if.action       <= next_item.action;
                item_if.key_code     <= next_item.key_code;
                item_if.preset_index <= next_item.preset_index;
            end
            else
            begin
                item_if.valid <= 1'b0;
            end
        end
    end

    // Result receiver. Ready drops in random bursts and for the whole
    // hold-off stretch, during which the block has to stall its input.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if ($urandom_range(0, 99) == 0)
                recv_calm = !recv_calm;
            if (stall_on)
            begin
                result_if.ready <= 1'b0;
            end
            else if (quiet_tail)
            begin
                result_if.ready <= 1'b1;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                result_if.ready <= 1'b0;
            end
            else if (!recv_calm && $urandom_range(0, 9) == 0)
            begin
                recv_gap = $urandom_range(1, 18) - 1;
                result_if.ready <= 1'b0;
            end
            else
            begin
                result_if.ready <= 1'b1;
            end
        end
    end

    // Long receiver hold-off, counted here in cycles once it is requested.
    initial
    begin
        stall_on = 1'b0;
        wait (pressure_go);
        @(posedge clk);
        stall_on = 1'b1;
        repeat (STALL_CYCLES) @(posedge clk);
        stall_on = 1'b0;
    end

    // Monitor and scoreboard. A readout transfer is matched against the
    // oldest prediction first; an event transfer at the same edge only adds
    // a prediction, since its readout cannot come back that early.
    always @(posedge clk)
    begin : check_readouts
        kmt_result_t want;
        kmt_item_t   ev;
        if (rst_n)
        begin
            if (result_if.valid && result_if.ready)
            begin
                if (predicted_readouts.size() == 0)
                begin
                    errors++;
                    $display("%0t: readout with nothing expected, actual mm:ss %0d:%0d",
                             $time, result_if.minutes_left, result_if.seconds_left);
                end
                else
                begin
                    want = predicted_readouts.pop_front();
                    readouts_checked++;
                    if (want.done_pulse)
                        countdowns_done++;
                    check_field("running", 16'(want.running), 16'(result_if.running));
                    check_field("minutes_left", 16'(want.minutes_left),
                                16'(result_if.minutes_left));
                    check_field("seconds_left", 16'(want.seconds_left),
                                16'(result_if.seconds_left));
                    check_field("digits_entered", 16'(want.digits_entered),
                                16'(result_if.digits_entered));
                    check_field("beep_count", 16'(want.beep_count),
                                16'(result_if.beep_count));
                    check_field("done_pulse", 16'(want.done_pulse),
                                16'(result_if.done_pulse));
                    check_field("motor_on", 16'(want.motor_on), 16'(result_if.motor_on));
                end
            end
            if (item_if.valid && item_if.ready)
            begin
                item_taken = 1'b1;
                ev.action       = item_if.action;
                ev.key_code     = item_if.key_code;
                ev.preset_index = item_if.preset_index;
                predicted_readouts.push_back(timer_advance(model_state, ev));
                events_accepted++;
            end
        end
    end

    initial
    begin
        int p;
        int i;
        int pick;
        rst_n                = 1'b0;
        cfg_wr_en            = 1'b0;
        cfg_index            = '0;
        cfg_wdata            = '0;
        item_if.valid        = 1'b0;
        item_if.action       = ACT_KEY;
        item_if.key_code     = '0;
        item_if.preset_index = '0;
        result_if.ready      = 1'b0;
        plan_state           = '0;
        model_state          = '0;
        for (i = 0; i < PRESET_COUNT; i++)
            preset_secs[i] = PRESET_DEFAULTS[i];
        settings_used = 1;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part on the reset presets: events that must be ignored,
        // an all-zero entry that starts at 00:00 and ends on the next tick,
        // and an all-nines entry whose seconds carry into 100:39.
        queue_event(ACT_TICK, 4'd0, 3'd0);
        queue_event(ACT_NONE, 4'd15, 3'd7);
        queue_event(ACT_KEY, KEY_STAR, 3'd0);
        queue_event(ACT_KEY, KEY_HASH, 3'd0);
        queue_event(ACT_KEY, 4'd15, 3'd0);
        queue_event(ACT_PRESET, 4'd0, 3'd7);
        for (i = 0; i < ENTRY_DIGITS; i++)
            queue_event(ACT_KEY, 4'd0, 3'd0);
        queue_event(ACT_TICK, 4'd0, 3'd0);
        for (i = 0; i < ENTRY_DIGITS; i++)
            queue_event(ACT_KEY, KEY_DIGIT_MAX, 3'd0);
        queue_event(ACT_KEY, 4'd5, 3'd0);
        queue_event(ACT_TICK, 4'd0, 3'd0);
        wait_until_idle();

        // Directed part on edge presets: a minute borrow, a reload while
        // running that saturates, a zero preset, and a preset that starts
        // the timer over a half-typed entry, which done then clears.
        write_preset(0, 13'd0);
        write_preset(1, 13'd8191);
        write_preset(2, 13'd6039);
        write_preset(3, 13'd60);
        write_preset(4, 13'd59);
        write_preset(5, 13'd1);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        settings_used++;
        queue_event(ACT_PRESET, 4'd0, 3'd3);
        queue_event(ACT_TICK, 4'd0, 3'd0);
        queue_event(ACT_PRESET, 4'd0, 3'd1);
        queue_event(ACT_PRESET, 4'd0, 3'd0);
        queue_event(ACT_TICK, 4'd0, 3'd0);
        queue_event(ACT_KEY, 4'd1, 3'd0);
        queue_event(ACT_KEY, 4'd2, 3'd0);
        queue_event(ACT_PRESET, 4'd0, 3'd5);
        repeat (3) queue_event(ACT_TICK, 4'd0, 3'd0);
        wait_until_idle();

        // Random phases, each on a fresh preset setting. Every setting keeps
        // at least one short preset so that long countdowns can be cut.
        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            for (i = 0; i < PRESET_COUNT; i++)
            begin
                if (p == 0)
                    write_preset(i, cfg_data_t'($urandom_range(0, 40)));
                else if (p == 1)
                    write_preset(i, PRESET_EDGES[i]);
                else
                begin
                    pick = $urandom_range(0, 7);
                    if (pick < 6)
                        write_preset(i, cfg_data_t'($urandom_range(0, 120)));
                    else if (pick == 6)
                        write_preset(i, cfg_data_t'($urandom_range(0, 8191)));
                    else
                        write_preset(i, PRESET_EDGES[$urandom_range(0, 2)]);
                end
            end
            if (p > 1)
                write_preset($urandom_range(0, PRESET_COUNT - 1),
                             cfg_data_t'($urandom_range(0, 30)));
            @(negedge clk);
            cfg_wr_en <= 1'b0;
            settings_used++;
            if (p == RANDOM_PHASES - 1)
                quiet_tail = 1'b1;
            plan_random_events(PHASE_EVENTS);
            if (p == 2)
                pressure_go = 1'b1;
            wait_until_idle();
        end

        repeat (8) @(posedge clk);
        $display("testbench: %0d events transferred, %0d readouts checked, %0d countdowns run out",
                 events_accepted, readouts_checked, countdowns_done);
        $display("testbench: %0d preset settings used, one long receiver hold-off",
                 settings_used);
        if (errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #5_000_000;
        $display("testbench: done, errors");
        $finish;
    end

endmodule
